[rtl/scba_pkg.sv]
// Shared types and constants for the six-channel boxcar average scaler.
`default_nettype none

package scba_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 16;
  localparam int VDDA_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int NUM_RANKS  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MV_PROD_W  = SAMPLE_W + VDDA_W;
  localparam int LVL_PROD_W = SAMPLE_W + GAIN_W;

  localparam logic [VDDA_W-1:0] VDDA_RESET = 12'd3300;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [SAMPLE_W:0] FULL_SCALE = 13'd4095;

  localparam logic [CFG_IDX_W-1:0] REG_VDDA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN0 = 3'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic [SAMPLE_W-1:0] sample2;
    logic [SAMPLE_W-1:0] sample3;
    logic [SAMPLE_W-1:0] sample4;
    logic [SAMPLE_W-1:0] sample5;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level0;
    logic [LEVEL_W-1:0] level1;
    logic [LEVEL_W-1:0] level2;
    logic [LEVEL_W-1:0] level3;
    logic [LEVEL_W-1:0] level4;
    logic [LEVEL_W-1:0] level5;
  } out_t;

endpackage

`default_nettype wire

[rtl/six_channel_boxcar_average_scaler_core.sv]
// Top level of the six-channel boxcar average scaler.
//
// The input channel carries one ADC scan per beat (six 12-bit samples); the
// output channel carries one beat of six 16-bit scaled levels per scan. Both
// use valid/ready. Configuration is a plain write port: index 0 is the
// reference voltage in millivolts, indexes 1 to 6 the Q4.12 gains.
// A scan row of the sample history lives in one RAM of WINDOW rows; accepting
// a beat reads the old row, which is written back with the new samples on the
// next cycle. The channels then pass one per cycle through a shared
// five-stage scaling pipeline (window sum, reciprocal multiply for the
// average, millivolt multiply, divide by 4095, gain multiply).
// The output beat becomes valid once the last channel has left the pipeline,
// and a new beat is accepted only after the previous scan has drained from
// it, since the channels share the one pipeline.
// A finished result waits in the output register while the next scan is
// taken; if the receiver still stalls when the following result is done, the
// block holds it and drops input ready until the output register frees.
// Reset (synchronous) clears the window sums and the write position, marks the
// history empty, restores the register defaults, and needs no clearing pass.
`default_nettype none

module six_channel_boxcar_average_scaler_core #(
  parameter int WINDOW   = 16,
  parameter int CHANNELS = 6
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire scba_pkg::in_t                         in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output scba_pkg::out_t                             out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [scba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [scba_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SW      = scba_pkg::SAMPLE_W;
  localparam int LW      = scba_pkg::LEVEL_W;
  localparam int NR      = scba_pkg::NUM_RANKS;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W   = SW + $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int ROW_W   = CHANNELS * SW;
  localparam int MVP_W   = scba_pkg::MV_PROD_W;
  localparam int LVP_W   = scba_pkg::LVL_PROD_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]  state;
  logic [CH_W-1:0] ch;
  logic [SLOT_W-1:0] slot;
  logic        filled;
  logic        rd_live;
  logic        accept;
  logic        out_free;

  logic [scba_pkg::VDDA_W-1:0] vdda;
  logic [scba_pkg::GAIN_W-1:0] gains [CHANNELS];
  logic [SUM_W-1:0]            sums  [CHANNELS];
  logic [LW-1:0]               levels [CHANNELS];

  logic [NR*SW-1:0] in_flat;
  logic [ROW_W-1:0] new_row;
  logic [ROW_W-1:0] rd_row;
  logic [SW-1:0]    new_smp [CHANNELS];
  logic [SW-1:0]    old_smp [CHANNELS];
  logic [SUM_W-1:0] sum_next;
  logic [NR*LW-1:0] out_flat;
  logic             ram_we;

  logic             v1, v2, v3, v4;
  logic [CH_W-1:0]  c1, c2, c3, c4;
  logic [SUM_W-1:0] s1_sum;
  logic [PROD_W-1:0] p2;
  logic [MVP_W-1:0] x3;
  logic [SW-1:0]    mv4;
  logic [SW-1:0]    avg;
  logic [SW-1:0]    q0;
  logic [SW:0]      rem;
  logic [SW-1:0]    mv_next;
  logic [LVP_W-1:0] lvl_prod;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || ((state == ST_FINISH) && out_free);
  assign accept   = in_valid && in_ready;
  assign ram_we   = (state == ST_RUN) && (ch == '0);

  assign in_flat = in_data;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    assign new_smp[k] = new_row[k*SW +: SW];
    assign old_smp[k] = rd_live ? rd_row[k*SW +: SW] : '0;
  end

  for (genvar k = 0; k < NR; k++) begin : g_rank
    if (k < CHANNELS) begin : g_on
      assign out_flat[(NR-1-k)*LW +: LW] = levels[k];
    end else begin : g_off
      assign out_flat[(NR-1-k)*LW +: LW] = '0;
    end
  end

  scba_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (new_row),
    .re    (accept),
    .raddr (slot),
    .rdata (rd_row)
  );

  always_comb begin
    sum_next = sums[ch] + SUM_W'(new_smp[ch]) - SUM_W'(old_smp[ch]);
    avg      = p2[SHIFT +: SW];
    q0       = x3[MVP_W-1 -: SW];
    rem      = (SW+1)'(x3[SW-1:0]) + (SW+1)'(q0);
    if (rem >= (scba_pkg::FULL_SCALE << 1)) begin
      mv_next = q0 + SW'(2);
    end else if (rem >= scba_pkg::FULL_SCALE) begin
      mv_next = q0 + SW'(1);
    end else begin
      mv_next = q0;
    end
    lvl_prod = LVP_W'(mv4) * LVP_W'(gains[c4]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdda <= scba_pkg::VDDA_RESET;
      for (int k = 0; k < CHANNELS; k++) begin
        gains[k] <= scba_pkg::GAIN_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == scba_pkg::REG_VDDA) begin
        vdda <= cfg_data[scba_pkg::VDDA_W-1:0];
      end
      for (int k = 0; k < CHANNELS; k++) begin
        if (cfg_index == scba_pkg::REG_GAIN0 + scba_pkg::CFG_IDX_W'(k)) begin
          gains[k] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= '0;
      slot      <= '0;
      filled    <= 1'b0;
      rd_live   <= 1'b0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        sums[k] <= '0;
      end
    end else begin
      v1 <= (state == ST_RUN);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (accept) begin
        rd_live <= filled;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        slot <= (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
        if (slot == SLOT_LAST) begin
          filled <= 1'b1;
        end
      end
      if (state == ST_RUN) begin
        sums[ch] <= sum_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (ch == CH_LAST) begin
            ch    <= '0;
            state <= ST_DRAIN;
          end else begin
            ch <= ch + CH_W'(1);
          end
        end
        ST_DRAIN: begin
          if (v4 && c4 == CH_LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (accept) begin
            state <= ST_RUN;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < CHANNELS; k++) begin
        new_row[k*SW +: SW] <= in_flat[(NR-1-k)*SW +: SW];
      end
    end
    if (state == ST_FINISH && out_free) begin
      out_data <= scba_pkg::out_t'(out_flat);
    end
    c1     <= ch;
    c2     <= c1;
    c3     <= c2;
    c4     <= c3;
    s1_sum <= sum_next;
    p2     <= PROD_W'(s1_sum) * PROD_W'(RECIP);
    x3     <= MVP_W'(avg) * MVP_W'(vdda);
    mv4    <= mv_next;
    if (v4) begin
      levels[c4] <= lvl_prod[LVP_W-1 -: LW];
    end
  end

`ifndef ASSERT_OFF
  a_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(v1 || v2 || v3 || v4))
    else $error("input taken while the scaling pipeline is busy");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (ch == '0))
    else $error("accepted scan did not start at the first channel");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && out_free |=> out_valid)
    else $error("finished result was not loaded into the output register");
`endif

endmodule

`default_nettype wire

[rtl/scba_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
